>>> src/fft_pkg.sv
package fft_pkg;

    localparam int SAMPLE_W = 16;
    localparam int ACC_W    = 24;
    localparam int MAG_W    = 23;
    localparam int BIN_W    = 6;
    localparam int TW_W     = 16;
    localparam int ROM_LOG2 = 7;
    localparam int ROM_DEPTH = 128;
    localparam int MAX_BINS = 64;
    localparam int SQ_W     = 48;
    localparam logic [MAG_W-1:0] MAG_MAX = 23'd4194304;
    localparam logic signed [ACC_W-1:0] ACC_MAX = 24'sd8388607;
    localparam logic signed [ACC_W-1:0] ACC_MIN = -24'sd8388608;

    typedef enum logic [3:0] {
        S_IDLE, S_RD, S_WAIT, S_MUL, S_RND, S_WR1, S_WR2,
        S_MRD, S_MWAIT, S_MSQ, S_MSUM, S_ROOT, S_OUT
    } t_state;

    function automatic logic signed [TW_W-1:0] quarter_sine(input logic [5:0] k);
        logic signed [TW_W-1:0] v;
        case (k)
            6'd0: v = 16'sd0;      6'd1: v = 16'sd1608;   6'd2: v = 16'sd3212;
            6'd3: v = 16'sd4808;   6'd4: v = 16'sd6393;   6'd5: v = 16'sd7962;
            6'd6: v = 16'sd9512;   6'd7: v = 16'sd11039;  6'd8: v = 16'sd12540;
            6'd9: v = 16'sd14010;  6'd10: v = 16'sd15447; 6'd11: v = 16'sd16846;
            6'd12: v = 16'sd18205; 6'd13: v = 16'sd19520; 6'd14: v = 16'sd20788;
            6'd15: v = 16'sd22006; 6'd16: v = 16'sd23170; 6'd17: v = 16'sd24279;
            6'd18: v = 16'sd25330; 6'd19: v = 16'sd26320; 6'd20: v = 16'sd27246;
            6'd21: v = 16'sd28106; 6'd22: v = 16'sd28899; 6'd23: v = 16'sd29622;
            6'd24: v = 16'sd30274; 6'd25: v = 16'sd30853; 6'd26: v = 16'sd31357;
            6'd27: v = 16'sd31786; 6'd28: v = 16'sd32138; 6'd29: v = 16'sd32413;
            6'd30: v = 16'sd32610; 6'd31: v = 16'sd32729; default: v = 16'sd32767;
        endcase
        return v;
    endfunction

    function automatic logic signed [TW_W-1:0] rom_sine(input logic [ROM_LOG2-1:0] t);
        logic [7:0] u;
        logic signed [TW_W-1:0] v;
        u = {1'b0, t};
        if (u <= 8'd32)      v = quarter_sine(u[5:0]);
        else if (u <= 8'd64) v = quarter_sine(6'(8'd64 - u));
        else if (u <= 8'd96) v = -quarter_sine(6'(u - 8'd64));
        else                 v = -quarter_sine(6'(8'd128 - u));
        return v;
    endfunction

    function automatic logic signed [ACC_W-1:0] sat24(input logic signed [ACC_W+1:0] v);
        logic signed [ACC_W-1:0] r;
        if (v > 26'(ACC_MAX))      r = ACC_MAX;
        else if (v < 26'(ACC_MIN)) r = ACC_MIN;
        else                       r = v[ACC_W-1:0];
        return r;
    endfunction

endpackage

>>> src/fft128_magnitude_spectrum_core.sv
// channel   | dir | tdata                        | tuser | tlast
// s_axis    | in  | [15:0] sample (signed)       | -     | -
// m_axis    | out | [5:0] bin_index, [28:6] mag  | -     | last_bin
//
// Samples are taken one per cycle through a two-word queue while the back end
// is idle; the 128th word starts the transform. Each of the 448 butterflies
// runs on the single shared multiply unit and store port, and each of the
// 64 bins then goes in turn through the one-bit-per-pass root unit.
// Synchronous active-low reset clears control only; the sample store is
// undefined until written. A stalled output word holds until taken.
module fft128_magnitude_spectrum_core #(
    parameter int POINTS = 128,
    parameter int LOG2_POINTS = 7
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,   // [15:0] sample
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata,   // [5:0] bin_index, [28:6] magnitude, zero fill
    output logic        m_axis_tlast
);
    import fft_pkg::*;

    logic                          q_valid, q_ready;
    logic [LOG2_POINTS+SAMPLE_W:0] q_word;
    logic [BIN_W-1:0]              bin;
    logic [MAG_W-1:0]              mag;

    // front: number and bit-reverse arriving words
    fft_front #(.POINTS(POINTS), .LOG2_POINTS(LOG2_POINTS)) u_front (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(s_axis_tvalid), .o_ready(s_axis_tready), .i_sample(s_axis_tdata),
        .o_valid(q_valid), .i_ready(q_ready), .o_word(q_word)
    );

    // back: store, butterflies, magnitudes
    fft_back #(.POINTS(POINTS), .LOG2_POINTS(LOG2_POINTS)) u_back (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_valid(q_valid), .o_ready(q_ready), .i_word(q_word),
        .o_valid(m_axis_tvalid), .i_ready(m_axis_tready),
        .o_bin(bin), .o_mag(mag), .o_last(m_axis_tlast)
    );

    assign m_axis_tdata = {3'b000, mag, bin};
endmodule

>>> src/fft_front.sv
module fft_front #(
    parameter int POINTS = 128,
    parameter int LOG2_POINTS = 7
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [fft_pkg::SAMPLE_W-1:0]  i_sample,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [LOG2_POINTS+fft_pkg::SAMPLE_W:0] o_word
);
    import fft_pkg::*;

    // queue word: {frame_end, addr, sample}
    localparam int QW = LOG2_POINTS + SAMPLE_W + 1;
    logic [QW-1:0] r_q0, r_q1;
    logic          r_v0, r_v1;
    logic [LOG2_POINTS-1:0] r_cnt;
    logic [LOG2_POINTS-1:0] rev;
    logic          push, pop;

    always_comb begin
        for (int b = 0; b < LOG2_POINTS; b++) rev[b] = r_cnt[LOG2_POINTS-1-b];
    end

    assign o_ready = !r_v1;
    assign push    = i_valid && o_ready;
    assign o_valid = r_v0;
    assign o_word  = r_q0;
    assign pop     = r_v0 && i_ready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= '0;
            r_v0  <= 1'b0;
            r_v1  <= 1'b0;
        end else begin
            if (push) r_cnt <= r_cnt + 1'b1;
            // two-entry queue, entry 0 is the head
            if (pop) begin
                r_v0 <= r_v1 || push;
                r_v1 <= r_v1 && push;
            end else if (push) begin
                if (!r_v0) r_v0 <= 1'b1;
                else       r_v1 <= 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (pop) begin
            r_q0 <= r_v1 ? r_q1 : {&r_cnt, rev, i_sample};
            if (r_v1 && push) r_q1 <= {&r_cnt, rev, i_sample};
        end else if (push) begin
            if (!r_v0) r_q0 <= {&r_cnt, rev, i_sample};
            else       r_q1 <= {&r_cnt, rev, i_sample};
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n) r_v1 |-> r_v0)
        else $error("queue tail valid without head");
    assert property (@(posedge i_clk) disable iff (!i_rst_n) !r_v0 |=> !(r_v1 && $rose(r_v1)))
        else $error("tail filled over empty head");
    assert property (@(posedge i_clk) disable iff (!i_rst_n) push |=> r_cnt == $past(r_cnt) + 1'b1)
        else $error("sample counter skipped");
endmodule

>>> src/fft_back.sv
module fft_back #(
    parameter int POINTS = 128,
    parameter int LOG2_POINTS = 7
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic [LOG2_POINTS+fft_pkg::SAMPLE_W:0] i_word,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic [fft_pkg::BIN_W-1:0]     o_bin,
    output logic [fft_pkg::MAG_W-1:0]     o_mag,
    output logic                          o_last
);
    import fft_pkg::*;

    localparam int AW = LOG2_POINTS;
    localparam int SW = $clog2(LOG2_POINTS + 1);
    localparam int NB = (POINTS / 2 > MAX_BINS) ? MAX_BINS : POINTS / 2;

    logic signed [ACC_W-1:0] mem_re [POINTS];
    logic signed [ACC_W-1:0] mem_im [POINTS];

    t_state r_st, n_st;
    logic [SW-1:0] r_stage, n_stage;
    logic [AW-1:0] r_j, n_j, r_k, n_k;
    logic [AW-1:0] half, ia, ix;
    logic [AW:0]   kn;
    logic [AW-1:0] p;
    logic [ROM_LOG2-1:0] tix;
    logic signed [TW_W-1:0] r_c, r_s;
    logic signed [ACC_W-1:0] r_ar, r_ai, r_xr, r_xi;
    logic signed [ACC_W-1:0] rd_re, rd_im;
    logic signed [ACC_W+TW_W-1:0] r_m0, r_m1, r_m2, r_m3;
    logic signed [ACC_W+TW_W+1:0] sr, si;
    logic signed [ACC_W+1:0] r_tr, r_ti;
    logic [AW-1:0] rd_addr;
    logic [SQ_W-1:0] r_sq0, r_sq1;
    // root unit: one result bit per pass, remainder left in r_x
    logic [SQ_W:0] r_x, r_r, r_bit;
    logic [BIN_W-1:0] r_bin;
    logic [MAG_W-1:0] r_mag;
    logic [SQ_W:0] rb;
    logic [SQ_W:0] mg;

    assign half = AW'(1) << (r_stage - 1'b1);
    assign ia   = r_k;
    assign ix   = r_k + half;
    assign kn   = {1'b0, r_k} + {half, 1'b0};
    assign p    = AW'(r_j << (LOG2_POINTS - r_stage));
    assign tix  = (LOG2_POINTS >= ROM_LOG2) ? ROM_LOG2'(p >> (LOG2_POINTS - ROM_LOG2))
                                            : ROM_LOG2'({p, {(ROM_LOG2 > LOG2_POINTS ?
                                              ROM_LOG2 - LOG2_POINTS : 1){1'b0}}});
    assign o_ready = (r_st == S_IDLE);
    assign o_valid = (r_st == S_OUT);
    assign o_bin   = r_bin;
    assign o_mag   = r_mag;
    assign o_last  = (r_bin == BIN_W'(NB - 1));
    assign sr = (ACC_W+TW_W+2)'(r_m0) + (ACC_W+TW_W+2)'(r_m1) + 16384;
    assign si = (ACC_W+TW_W+2)'(r_m2) - (ACC_W+TW_W+2)'(r_m3) + 16384;
    assign rb = r_r + r_bit;
    // round up when the remainder exceeds the floor root
    assign mg = r_r + ((r_x > r_r) ? 1'b1 : 1'b0);

    always_comb begin
        unique case (r_st)
            S_RD, S_WR1: rd_addr = (r_st == S_RD) ? ix : ix;
            default:     rd_addr = (r_st == S_MRD || r_st == S_MWAIT) ? AW'(r_bin) : ia;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (r_st == S_IDLE && i_valid) begin
            mem_re[i_word[SAMPLE_W +: AW]] <= ACC_W'($signed(i_word[SAMPLE_W-1:0]));
            mem_im[i_word[SAMPLE_W +: AW]] <= '0;
        end else if (r_st == S_WR1) begin
            mem_re[ia] <= sat24((ACC_W+2)'(r_ar) + r_tr);
            mem_im[ia] <= sat24((ACC_W+2)'(r_ai) + r_ti);
        end else if (r_st == S_WR2) begin
            mem_re[ix] <= sat24((ACC_W+2)'(r_ar) - r_tr);
            mem_im[ix] <= sat24((ACC_W+2)'(r_ai) - r_ti);
        end
        rd_re <= mem_re[r_st == S_RD ? ia : rd_addr];
        rd_im <= mem_im[r_st == S_RD ? ia : rd_addr];
    end

    always_ff @(posedge i_clk) begin
        unique case (r_st)
            S_RD: begin
                r_c <= rom_sine(tix + ROM_LOG2'(32));
                r_s <= rom_sine(tix);
            end
            S_WAIT: begin
                r_ar <= rd_re;
                r_ai <= rd_im;
                r_xr <= mem_re[ix];
                r_xi <= mem_im[ix];
            end
            S_MUL: begin
                r_m0 <= r_xr * r_c;
                r_m1 <= r_xi * r_s;
                r_m2 <= r_xi * r_c;
                r_m3 <= r_xr * r_s;
            end
            S_RND: begin
                r_tr <= (ACC_W+2)'(sr >>> 15);
                r_ti <= (ACC_W+2)'(si >>> 15);
            end
            S_MSQ: begin
                r_sq0 <= $unsigned(SQ_W'(rd_re) * SQ_W'(rd_re));
                r_sq1 <= $unsigned(SQ_W'(rd_im) * SQ_W'(rd_im));
            end
            S_MSUM: begin
                r_x   <= {1'b0, r_sq0} + {1'b0, r_sq1};
                r_r   <= '0;
                r_bit <= (SQ_W+1)'(1) << (SQ_W - 2 + (SQ_W % 2));
            end
            S_ROOT: begin
                if (r_bit != '0) begin
                    if (r_x >= rb) begin
                        r_x <= r_x - rb;
                        r_r <= (r_r >> 1) + r_bit;
                    end else begin
                        r_r <= r_r >> 1;
                    end
                    r_bit <= r_bit >> 2;
                end else begin
                    r_mag <= (mg > (SQ_W+1)'(MAG_MAX)) ? MAG_MAX : MAG_W'(mg);
                end
            end
            default: ;
        endcase
    end

    always_comb begin
        n_st = r_st; n_stage = r_stage; n_j = r_j; n_k = r_k;
        unique case (r_st)
            S_IDLE: if (i_valid && i_word[SAMPLE_W+AW]) begin
                n_st = S_RD; n_stage = SW'(1); n_j = '0; n_k = '0;
            end
            S_RD:   n_st = S_WAIT;
            S_WAIT: n_st = S_MUL;
            S_MUL:  n_st = S_RND;
            S_RND:  n_st = S_WR1;
            S_WR1:  n_st = S_WR2;
            S_WR2: begin
                n_st = S_RD;
                if (kn < (AW+1)'(POINTS) && kn[AW-1:0] + half >= kn[AW-1:0]
                    && kn + half < (AW+1)'(POINTS)) begin
                    n_k = kn[AW-1:0];
                end else if (r_j + 1'b1 < half) begin
                    n_j = r_j + 1'b1; n_k = r_j + 1'b1;
                end else if (r_stage < SW'(LOG2_POINTS)) begin
                    n_stage = r_stage + 1'b1; n_j = '0; n_k = '0;
                end else begin
                    n_st = S_MRD;
                end
            end
            S_MRD:   n_st = S_MWAIT;
            S_MWAIT: n_st = S_MSQ;
            S_MSQ:   n_st = S_MSUM;
            S_MSUM:  n_st = S_ROOT;
            S_ROOT:  if (r_bit == '0) n_st = S_OUT;
            S_OUT: if (i_ready) begin
                n_st = (r_bin == BIN_W'(NB - 1)) ? S_IDLE : S_MRD;
            end
            default: n_st = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= S_IDLE; r_stage <= SW'(1); r_j <= '0; r_k <= '0; r_bin <= '0;
        end else begin
            r_st <= n_st; r_stage <= n_stage; r_j <= n_j; r_k <= n_k;
            if (r_st == S_WR2 && n_st == S_MRD) r_bin <= '0;
            else if (r_st == S_OUT && i_ready) r_bin <= r_bin + 1'b1;
        end
    end

    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == S_OUT && !i_ready) |=> (r_st == S_OUT && $stable(r_mag)))
        else $error("result changed while stalled");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_st == S_WR1) |=> (r_st == S_WR2))
        else $error("butterfly write pair split");
    assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_stage >= SW'(1) && r_stage <= SW'(LOG2_POINTS))
        else $error("stage counter out of range");
endmodule

>>> bench/fft_spectrum_checker.sv
module fft_spectrum_checker (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    input  logic        i_s_tready,
    input  logic [15:0] i_s_tdata,    // [15:0] sample
    input  logic        i_m_tvalid,
    input  logic        i_m_tready,
    input  logic [31:0] i_m_tdata,    // [5:0] bin_index, [28:6] magnitude
    input  logic        i_m_tlast,    // last_bin
    output int          o_fail_count,
    output int          o_pending
);
    import fft_pkg::*;

    typedef struct packed {
        logic [BIN_W-1:0] bin;
        logic [MAG_W-1:0] mag;
        logic             last;
    } t_bin_word;

    t_bin_word   spectrum_q[$];
    longint      frame_re[128];
    longint      frame_im[128];
    int unsigned frame_fill;

    assign o_pending = spectrum_q.size();

    function automatic int unsigned bitrev7(input int unsigned v);
        int unsigned r;
        r = 0;
        for (int b = 0; b < 7; b++) r = (r << 1) | ((v >> b) & 1);
        return r;
    endfunction

    function automatic longint q15_round(input longint v);
        return (v + 16384) >>> 15;
    endfunction

    function automatic longint clip24(input longint v);
        if (v > 8388607) return 8388607;
        if (v < -8388608) return -8388608;
        return v;
    endfunction

    function automatic longint sine_q15(input int unsigned t);
        int unsigned u;
        u = t & 127;
        if (u <= 32) return quarter_sine(6'(u));
        if (u <= 64) return quarter_sine(6'(64 - u));
        if (u <= 96) return -longint'(quarter_sine(6'(u - 64)));
        return -longint'(quarter_sine(6'(128 - u)));
    endfunction

    function automatic longint unsigned round_sqrt(input longint unsigned n);
        longint unsigned r, bitv, x;
        r = 0;
        bitv = 64'd1 << 62;
        x = n;
        while (bitv > x) bitv >>= 2;
        while (bitv != 0) begin
            if (x >= r + bitv) begin
                x -= r + bitv;
                r = (r >> 1) + bitv;
            end else begin
                r >>= 1;
            end
            bitv >>= 2;
        end
        if (n - r * r > r) r++;
        return r;
    endfunction

    // Run the transform in place and queue the 64 expected bin words.
    task automatic transform_frame();
        longint c, s, ar, ai, xr, xi, tr, ti;
        longint unsigned mag;
        int unsigned half, span, tw;
        t_bin_word w;
        for (int stage = 1; stage <= 7; stage++) begin
            half = 1 << (stage - 1);
            span = half << 1;
            for (int j = 0; j < half; j++) begin
                tw = (j * (128 >> stage)) & 127;
                c = sine_q15(tw + 32);
                s = sine_q15(tw);
                for (int k = j; k + half < 128; k += span) begin
                    ar = frame_re[k];
                    ai = frame_im[k];
                    xr = frame_re[k + half];
                    xi = frame_im[k + half];
                    tr = q15_round(xr * c + xi * s);
                    ti = q15_round(xi * c - xr * s);
                    frame_re[k] = clip24(ar + tr);
                    frame_im[k] = clip24(ai + ti);
                    frame_re[k + half] = clip24(ar - tr);
                    frame_im[k + half] = clip24(ai - ti);
                end
            end
        end
        for (int i = 0; i < 64; i++) begin
            mag = round_sqrt(longint'(frame_re[i] * frame_re[i] + frame_im[i] * frame_im[i]));
            if (mag > 4194304) mag = 4194304;
            w.bin = BIN_W'(i);
            w.mag = MAG_W'(mag);
            w.last = (i == 63);
            spectrum_q.push_back(w);
        end
    endtask

    task automatic report_mismatch(input string what, input longint got, input longint want);
        $display("mismatch %s: got %0d, want %0d", what, got, want);
        o_fail_count++;
    endtask

    always @(posedge i_clk) begin
        t_bin_word w;
        if (!i_rst_n) begin
            frame_fill = 0;
            o_fail_count = 0;
        end else begin
            if (i_s_tvalid && i_s_tready) begin
                frame_re[bitrev7(frame_fill)] = longint'($signed(i_s_tdata));
                frame_im[bitrev7(frame_fill)] = 0;
                frame_fill++;
                if (frame_fill == 128) begin
                    frame_fill = 0;
                    transform_frame();
                end
            end
            if (i_m_tvalid && i_m_tready) begin
                if (spectrum_q.size() == 0) begin
                    report_mismatch("unexpected word, bin", i_m_tdata[5:0], -1);
                end else begin
                    w = spectrum_q.pop_front();
                    if (i_m_tdata[5:0] != w.bin)
                        report_mismatch("bin_index", i_m_tdata[5:0], w.bin);
                    if (i_m_tdata[28:6] != w.mag)
                        report_mismatch("magnitude", i_m_tdata[28:6], w.mag);
                    if (i_m_tlast != w.last)
                        report_mismatch("last_bin", i_m_tlast, w.last);
                end
            end
        end
    end

endmodule

>>> bench/tb_fft128_magnitude_spectrum_core.sv
module tb_fft128_magnitude_spectrum_core;

    logic        i_clk;
    logic        i_rst_n;
    logic        s_axis_tvalid;
    logic        s_axis_tready;
    logic [15:0] s_axis_tdata;    // [15:0] sample
    logic        m_axis_tvalid;
    logic        m_axis_tready;
    logic [31:0] m_axis_tdata;    // [5:0] bin_index, [28:6] magnitude, zero fill
    logic        m_axis_tlast;    // last_bin

    int fail_count;
    int pending;
    int send_idle_pct;
    int recv_idle_pct;
    int hold_off;
    logic hold_start;
    int cycle_count = 0;

    fft128_magnitude_spectrum_core dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast)
    );

    fft_spectrum_checker checker_i (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .i_s_tvalid(s_axis_tvalid), .i_s_tready(s_axis_tready), .i_s_tdata(s_axis_tdata),
        .i_m_tvalid(m_axis_tvalid), .i_m_tready(m_axis_tready), .i_m_tdata(m_axis_tdata),
        .i_m_tlast(m_axis_tlast), .o_fail_count(fail_count), .o_pending(pending)
    );

    // Free-running 12-unit clock.
    initial i_clk = 1'b0;
    always begin
        #6 i_clk = 1'b1;
        #6 i_clk = 1'b0;
    end

    // Long receiver hold-off: count it down here once the stimulus asks for it.
    initial begin
        hold_off = 0;
        wait (hold_start);
        @(posedge i_clk);
        hold_off <= 60000;
        @(posedge i_clk);
        while (hold_off > 0) begin
            hold_off <= hold_off - 1;
            @(posedge i_clk);
        end
    end

    // Receiver: random stalls, plus the long hold-off so the
    // core fills up and backs pressure onto the sample input.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (hold_off > 0) begin
            m_axis_tready <= 1'b0;
        end else begin
            m_axis_tready <= ($urandom_range(99) >= recv_idle_pct);
        end
    end

    // Watchdog: generous bound over three full frames and a partial one at worst-case stalls.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 600000) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // Offer one sample; hold it until accepted, with random idle cycles first.
    task automatic send_sample(input logic [15:0] v);
        while ($urandom_range(99) < send_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= v;
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
    endtask

    // Pick a sample shaped by the frame style: full-scale noise, small noise, a full-scale square wave, tones.
    function automatic logic [15:0] pick_sample(input int style, input int n);
        case (style)
            0: return 16'($urandom);
            1: return 16'($signed($urandom_range(2000)) - 1000);
            2: return (n[3]) ? 16'h7FFF : 16'h8000;
            default: return 16'($rtoi(20000.0 * $sin(6.2831853 * n * style / 128.0)));
        endcase
    endfunction

    initial begin
        int frame_style;
        hold_start    = 1'b0;
        send_idle_pct = 0;
        recv_idle_pct = 0;
        i_rst_n       = 1'b0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata  = '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed frame: extremes, small values of both signs, a full-scale step.
        send_idle_pct = 14;
        recv_idle_pct = 72;
        for (int n = 0; n < 128; n++) begin
            if (n == 0)       send_sample(16'h7FFF);
            else if (n == 1)  send_sample(16'h8000);
            else if (n == 2)  send_sample(16'hFFFF);
            else if (n == 3)  send_sample(16'h0001);
            else if (n < 64)  send_sample(16'h8000);
            else              send_sample(16'h7FFF);
        end

        // Frames with idling swapped, then none; hold off the receiver
        // during the second so its output stalls and the input backs up.
        for (int f = 0; f < 2; f++) begin
            if (f == 0) begin
                send_idle_pct = 72;
                recv_idle_pct = 14;
            end else begin
                send_idle_pct = 0;
                recv_idle_pct = 0;
                hold_start <= 1'b1;
            end
            frame_style = (f == 0) ? 2 : $urandom_range(3, 0);
            for (int n = 0; n < 128; n++) send_sample(pick_sample(frame_style, n));
        end
        // Partial frame of random words, left incomplete.
        for (int n = 0; n < 46; n++) send_sample(16'($urandom));
        s_axis_tvalid <= 1'b0;

        while (pending != 0) @(posedge i_clk);
        repeat (2000) @(posedge i_clk);
        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
